// ----- hw/rtl/mtct_pkg.sv -----
package mtct_pkg;

    // Sizes of the converter reading, the histogram and the counters
    localparam int SAMPLE_BITS = 12;
    localparam int BIN_COUNT   = 256;
    localparam int BIN_BITS    = $clog2(BIN_COUNT);
    localparam int BIN_SHIFT   = SAMPLE_BITS - BIN_BITS;   // sizes keep BIN_BITS <= SAMPLE_BITS
    localparam int COUNT_BITS  = 24;
    localparam int ACC_BITS    = COUNT_BITS + 1;
    localparam int SCALE_BITS  = 16;
    localparam int RATE_BITS   = 32;
    localparam int PROD_BITS   = COUNT_BITS + SCALE_BITS;
    localparam int THR_BITS    = 8;

    // Stream packing
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((RATE_BITS + COUNT_BITS + THR_BITS + 7) / 8) * 8;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(60);

    // Transaction kinds carried in tuser
    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_TICK   = 1'b1
    } t_mode;

    typedef logic [BIN_BITS-1:0]   t_bin;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [ACC_BITS-1:0]   t_acc;

    localparam t_count COUNT_MAX = '1;

    // Histogram port control
    typedef struct packed {
        logic   rd_en;
        t_bin   rd_addr;
        logic   wr_en;
        t_bin   wr_addr;
        t_count wr_data;
        logic   clr;
    } t_hist_ctl;

endpackage

// ----- hw/rtl/mtct_hist.sv -----
module mtct_hist (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtct_pkg::t_hist_ctl i_ctl,
    output mtct_pkg::t_count   o_rdata
);
    import mtct_pkg::*;

    t_count             r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_valid;
    t_count             r_mem_q;
    logic               r_valid_q;

    // Bin storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_mem_q <= r_mem[i_ctl.rd_addr];
        end
    end

    // Per-bin valid bits; a bin not written since the last clear reads zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_q <= 1'b0;
        end else if (i_ctl.rd_en) begin
            r_valid_q <= r_valid[i_ctl.rd_addr];
        end
    end

    assign o_rdata = r_valid_q ? r_mem_q : '0;

endmodule

// ----- hw/rtl/mtct_unit.sv -----
module mtct_unit (
    input  mtct_pkg::t_acc   i_a,
    input  mtct_pkg::t_acc   i_b,
    input  mtct_pkg::t_count i_target,
    output mtct_pkg::t_acc   o_sum,
    output mtct_pkg::t_count o_sat,
    output logic             o_reach
);
    import mtct_pkg::*;

    // Shared adder: bin increment and running median sum
    assign o_sum   = i_a + i_b;
    assign o_sat   = (o_sum > t_acc'(COUNT_MAX)) ? COUNT_MAX : o_sum[COUNT_BITS-1:0];
    assign o_reach = (o_sum >= t_acc'(i_target));

endmodule

// ----- hw/rtl/median_threshold_crossing_tachometer.sv -----
// Adaptive-threshold crossing tachometer. A sample transaction (tuser = 0) bins the 12-bit
// reading into a 256-bin level histogram, counts it, and counts a rising crossing when
// the reading reaches the current threshold level times 16 after having been below it.
// A tick transaction (tuser = 1) walks the histogram for the median bin, makes it the new
// threshold and emits one result: crossings times count_scale (saturating at 32 bits), the
// sample count and the new threshold; histogram and counters then clear. A sample does
// one histogram read, then one write through the shared adder. A tick reads and adds
// each bin (ST_WRD, ST_WACC) up to the median bin, then multiplies (ST_MUL) and loads
// the result (ST_DONE), and it waits there while an earlier result is still not taken.
// No clearing pass is needed after reset. count_scale is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, it is not enforced.
module median_threshold_crossing_tachometer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                i_cfg_we,
    input  logic [mtct_pkg::SCALE_BITS-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [mtct_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,  // [11:0] sample, zero pad
    input  logic [0:0]                          i_s_axis_tuser,  // [0] mode
    // Result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mtct_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata   // [31:0] measured_rate,
                                                                 // [55:32] sample_total,
                                                                 // [63:56] new_threshold
);
    import mtct_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SWR  = 3'd1;
    localparam logic [2:0] ST_WRD  = 3'd2;
    localparam logic [2:0] ST_WACC = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [SCALE_BITS-1:0] r_scale;
    t_count                r_samples, r_cross, r_target;
    logic                  r_above;
    t_bin                  r_thr, r_found, r_idx, r_bin;
    t_acc                  r_acc;
    logic [PROD_BITS-1:0]  r_prod;
    logic                  r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;

    t_hist_ctl             hctl;
    t_count                hist_rdata;
    t_acc                  u_a, u_b, u_sum;
    t_count                u_sat;
    logic                  u_reach;

    logic                  in_acc, load_out;
    logic [SAMPLE_BITS-1:0] in_sample;
    t_bin                  in_bin;
    logic [RATE_BITS-1:0]  rate_sat;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_sample = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_bin    = t_bin'(in_sample >> BIN_SHIFT);
    assign load_out  = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    mtct_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hctl),
        .o_rdata (hist_rdata)
    );

    mtct_unit u_unit (
        .i_a      (u_a),
        .i_b      (u_b),
        .i_target (r_target),
        .o_sum    (u_sum),
        .o_sat    (u_sat),
        .o_reach  (u_reach)
    );

    // Shared adder operand select
    always_comb begin
        if (r_state == ST_SWR) begin
            u_a = t_acc'(hist_rdata);
            u_b = t_acc'(1);
        end else begin
            u_a = r_acc;
            u_b = t_acc'(hist_rdata);
        end
    end

    // Histogram port control
    always_comb begin
        hctl         = '0;
        hctl.wr_addr = r_bin;
        hctl.wr_data = u_sat;
        hctl.clr     = load_out;
        if (r_state == ST_IDLE) begin
            hctl.rd_en   = in_acc && (i_s_axis_tuser[0] == MODE_SAMPLE);
            hctl.rd_addr = in_bin;
        end else begin
            hctl.rd_en   = (r_state == ST_WRD);
            hctl.rd_addr = r_idx;
        end
        hctl.wr_en = (r_state == ST_SWR);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_axis_tuser[0] == MODE_SAMPLE) ? ST_SWR : ST_WRD;
                end
            end
            ST_SWR:  n_state = ST_IDLE;
            ST_WRD:  n_state = ST_WACC;
            ST_WACC: begin
                if (u_reach || r_idx == t_bin'(BIN_COUNT - 1)) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_WRD;
                end
            end
            ST_MUL:  n_state = ST_DONE;
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // Sample and crossing counters, threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= '0;
            r_cross   <= '0;
            r_above   <= 1'b0;
            r_thr     <= '0;
        end else if (load_out) begin
            r_samples <= '0;
            r_cross   <= '0;
            r_thr     <= r_found;
        end else if (in_acc && i_s_axis_tuser[0] == MODE_SAMPLE) begin
            if (r_samples != COUNT_MAX) begin
                r_samples <= r_samples + t_count'(1);
            end
            if (in_bin >= r_thr) begin
                if (!r_above && r_cross != COUNT_MAX) begin
                    r_cross <= r_cross + t_count'(1);
                end
                r_above <= 1'b1;
            end else begin
                r_above <= 1'b0;
            end
        end
    end

    // Sample bin, median walk and rate product
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_bin    <= in_bin;
            r_idx    <= '0;
            r_acc    <= '0;
            r_target <= r_samples >> 1;
        end
        if (r_state == ST_WACC) begin
            r_acc <= u_sum;
            r_idx <= r_idx + t_bin'(1);
            if (u_reach) begin
                r_found <= r_idx;
            end else if (r_idx == t_bin'(BIN_COUNT - 1)) begin
                r_found <= '0;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_BITS'(r_cross) * PROD_BITS'(r_scale);
        end
    end

    assign rate_sat = (r_prod[PROD_BITS-1:RATE_BITS] != '0) ? '1 : r_prod[RATE_BITS-1:0];

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= OUT_DATA_BITS'({r_found, r_samples, rate_sat});
        end
    end

`ifndef SYNTHESIS
    a_cross_le_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cross <= r_samples)
        else $error("crossing count above sample count");

    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (r_samples == '0 && r_cross == '0))
        else $error("counters not cleared with result");

    a_thr_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[RATE_BITS+COUNT_BITS +: THR_BITS] == r_thr))
        else $error("reported threshold differs from active threshold");

    a_walk_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRD) |-> (r_acc < t_acc'(r_target) || r_idx == '0))
        else $error("median walk ran past target");
`endif

endmodule

// ----- dv/tb_median_threshold_crossing_tachometer.sv -----
module tb_median_threshold_crossing_tachometer;

    timeunit 1ns;
    timeprecision 1ps;

    import mtct_pkg::*;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [THR_BITS-1:0]    t_thr;

    typedef struct {
        t_mode   mode;
        t_sample sample;
        bit      drain;     // hold this one until every pending report is back
    } t_stim;

    typedef struct packed {
        logic [RATE_BITS-1:0] rate;
        t_count               total;
        t_thr                 thr;
    } t_report;

    localparam int TOGGLE_PAIRS = 24;   // low/high sample pairs in the back-to-back period

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [SCALE_BITS-1:0]     i_cfg_wdata = '0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]   i_s_axis_tdata = '0;   // [11:0] sample, zero pad
    logic [0:0]                i_s_axis_tuser = '0;   // [0] mode
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata;        // [31:0] rate, [55:32] total, [63:56] thr

    median_threshold_crossing_tachometer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Tachometer state as seen by the checker
    t_count           hist_m [BIN_COUNT] = '{default: '0};
    t_count           samples_m = '0;
    t_count           crossings_m = '0;
    bit               above_m = 1'b0;
    t_thr             thr_m = '0;
    logic [SCALE_BITS-1:0] scale_m = SCALE_RESET;

    t_stim            stim_q [$];
    t_report          report_q [$];
    int unsigned      n_pushed = 0;
    int unsigned      n_taken = 0;
    int unsigned      n_fail = 0;
    int unsigned      src_max = 0;
    int unsigned      snk_max = 0;
    int unsigned      src_gap = 0;
    int unsigned      snk_gap = 0;
    bit               in_acc_q = 1'b0;
    bit               out_acc_q = 1'b0;

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the tachometer by one transaction; a tick queues its report
    task automatic tach_step(input t_mode mode, input t_sample s);
        int unsigned     bin;
        longint unsigned prod;
        longint unsigned target;
        longint unsigned run_sum;
        t_report         rpt;
        if (mode == MODE_SAMPLE) begin
            bin = int'((longint'(s) * BIN_COUNT) >> SAMPLE_BITS);
            if (bin >= BIN_COUNT) bin = BIN_COUNT - 1;
            hist_m[bin] = sat_inc(hist_m[bin]);
            samples_m   = sat_inc(samples_m);
            if (longint'(s) * BIN_COUNT >= (longint'(thr_m) << SAMPLE_BITS)) begin
                if (!above_m) begin
                    crossings_m = sat_inc(crossings_m);
                    above_m     = 1'b1;
                end
            end else begin
                above_m = 1'b0;
            end
        end else begin
            // median: first bin where the running sum reaches half the count
            target  = samples_m / 2;
            run_sum = 0;
            thr_m   = '0;
            for (int i = 0; i < BIN_COUNT; i++) begin
                run_sum += hist_m[i];
                if (run_sum >= target) begin
                    thr_m = THR_BITS'(i);
                    break;
                end
            end
            prod      = longint'(crossings_m) * longint'(scale_m);
            rpt.rate  = (prod > 64'hFFFF_FFFF) ? '1 : RATE_BITS'(prod);
            rpt.total = samples_m;
            rpt.thr   = thr_m;
            report_q.push_back(rpt);
            for (int i = 0; i < BIN_COUNT; i++) hist_m[i] = '0;
            samples_m   = '0;
            crossings_m = '0;
        end
    endtask

    // Source: presents queued items, random gap after each transaction
    always @(negedge i_clk) begin : source
        t_stim nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !in_acc_q) begin
            // hold until taken
        end else if (src_gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap         <= src_gap - 1;
        end else if (stim_q.size() != 0 && !(stim_q[0].drain && report_q.size() != 0)) begin
            nxt = stim_q.pop_front();
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= IN_DATA_BITS'(nxt.sample);
            i_s_axis_tuser  <= nxt.mode;
            src_gap         <= $urandom_range(0, src_max);
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Sink: random stall after each result transaction
    always @(negedge i_clk) begin : sink
        int unsigned w;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (out_acc_q) begin
            w = $urandom_range(0, snk_max);
            i_m_axis_tready <= (w == 0);
            snk_gap         <= (w == 0) ? 0 : w - 1;
        end else if (snk_gap != 0) begin
            i_m_axis_tready <= 1'b0;
            snk_gap         <= snk_gap - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Monitor: config tracking, result check, prediction on accepted input
    always @(posedge i_clk) begin : monitor
        t_report got;
        t_report want;
        in_acc_q  <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_acc_q <= i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_we) scale_m = i_cfg_wdata;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.rate  = o_m_axis_tdata[RATE_BITS-1:0];
                got.total = o_m_axis_tdata[RATE_BITS +: COUNT_BITS];
                got.thr   = o_m_axis_tdata[RATE_BITS+COUNT_BITS +: THR_BITS];
                if (report_q.size() == 0) begin
                    $error("unexpected result: measured_rate %0d sample_total %0d new_threshold %0d",
                           got.rate, got.total, got.thr);
                    n_fail++;
                end else begin
                    want = report_q.pop_front();
                    if (got.rate !== want.rate) begin
                        $error("measured_rate: expected %0d, got %0d", want.rate, got.rate);
                        n_fail++;
                    end
                    if (got.total !== want.total) begin
                        $error("sample_total: expected %0d, got %0d", want.total, got.total);
                        n_fail++;
                    end
                    if (got.thr !== want.thr) begin
                        $error("new_threshold: expected %0d, got %0d", want.thr, got.thr);
                        n_fail++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tach_step(t_mode'(i_s_axis_tuser[0]), i_s_axis_tdata[SAMPLE_BITS-1:0]);
                n_taken++;
            end
        end
    end

    task automatic push_item(input t_mode mode, input t_sample s, input bit drain);
        t_stim it;
        it.mode   = mode;
        it.sample = s;
        it.drain  = drain;
        stim_q.push_back(it);
        n_pushed++;
    endtask

    // Everything accepted, every report back, then let the last sample settle
    task automatic wait_idle();
        while (n_taken != n_pushed || report_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_BITS-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Periods of shaped waveforms, mostly closed by a tick
    task automatic run_random(input int unsigned n_items);
        int unsigned left;
        int unsigned shape;
        int unsigned len;
        int unsigned run;
        t_sample     lo;
        t_sample     hi;
        t_sample     s;
        bit          drain_next;
        left       = n_items;
        drain_next = 1'b1;
        while (left > 0) begin
            shape = $urandom_range(0, 9);
            len   = $urandom_range(1, 40);
            run   = $urandom_range(1, 6);
            lo    = SAMPLE_BITS'($urandom_range(0, 2047));
            hi    = SAMPLE_BITS'($urandom_range(2048, 4095));
            for (int k = 0; k < len && left > 0; k++) begin
                case (shape) inside
                    [0:4]: begin
                        s = ((k / run) % 2 == 1) ? hi - SAMPLE_BITS'($urandom_range(0, 7))
                                                 : lo + SAMPLE_BITS'($urandom_range(0, 7));
                    end
                    [5:6]: s = SAMPLE_BITS'($urandom_range(0, 4095));
                    7:     s = $urandom_range(0, 1) ? '1 : '0;
                    default: s = lo ^ SAMPLE_BITS'($urandom_range(0, 31));
                endcase
                push_item(MODE_SAMPLE, s, drain_next);
                drain_next = 1'b0;
                left--;
            end
            if (left > 0 && $urandom_range(0, 4) != 0) begin
                push_item(MODE_TICK, SAMPLE_BITS'($urandom), drain_next);
                left--;
                // an empty period now and then
                if (left > 0 && $urandom_range(0, 9) == 0) begin
                    push_item(MODE_TICK, SAMPLE_BITS'($urandom), 1'b0);
                    left--;
                end
                drain_next = ($urandom_range(0, 3) == 0);
            end
        end
        push_item(MODE_TICK, SAMPLE_BITS'($urandom), drain_next);
    endtask

    initial begin : stimulus
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset scale, empty period, threshold at an exact bin edge
        src_max = 3;
        snk_max = 3;
        push_item(MODE_TICK, '1, 1'b0);          // no samples: threshold bin 0
        push_item(MODE_SAMPLE, '0, 1'b0);        // reaches threshold 0
        push_item(MODE_SAMPLE, '1, 1'b0);
        push_item(MODE_SAMPLE, 12'd2048, 1'b0);
        push_item(MODE_SAMPLE, 12'd2048, 1'b0);
        push_item(MODE_TICK, '0, 1'b0);          // median -> bin 128
        push_item(MODE_SAMPLE, '1, 1'b0);        // above carried over the tick
        push_item(MODE_SAMPLE, 12'd2047, 1'b0);  // just below
        push_item(MODE_SAMPLE, 12'd2048, 1'b0);  // crossing at equality
        push_item(MODE_SAMPLE, 12'd2047, 1'b0);
        push_item(MODE_SAMPLE, 12'd2048, 1'b0);
        push_item(MODE_SAMPLE, '1, 1'b0);
        push_item(MODE_SAMPLE, '0, 1'b0);
        push_item(MODE_SAMPLE, '1, 1'b0);
        push_item(MODE_TICK, 12'h555, 1'b1);
        push_item(MODE_TICK, 12'hAAA, 1'b0);     // back-to-back, empty period
        wait_idle();

        // Zero scale: rate always zero
        write_scale('0);
        src_max = 4;
        snk_max = 4;
        run_random(300);
        wait_idle();

        // Unit scale, back-to-back traffic
        write_scale(16'd1);
        src_max = 0;
        snk_max = 0;
        run_random(250);
        wait_idle();

        write_scale('1);
        src_max = 2;
        snk_max = 3;
        run_random(250);
        wait_idle();

        // Threshold at bin 128, then back-to-back crossings across it
        src_max = 0;
        snk_max = 0;
        repeat (4) push_item(MODE_SAMPLE, 12'd2048, 1'b0);
        push_item(MODE_TICK, '0, 1'b0);
        for (int p = 0; p < TOGGLE_PAIRS; p++) begin
            push_item(MODE_SAMPLE, '0, 1'b0);
            push_item(MODE_SAMPLE, '1, 1'b0);
        end
        push_item(MODE_TICK, '0, 1'b0);
        wait_idle();

        write_scale(SCALE_BITS'($urandom_range(2, 65534)));
        src_max = 4;
        snk_max = 4;
        run_random(430);
        wait_idle();

        repeat (40) @(negedge i_clk);
        if (n_fail == 0 && report_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- median_threshold_crossing_tachometer.f -----
hw/rtl/mtct_pkg.sv
hw/rtl/mtct_hist.sv
hw/rtl/mtct_unit.sv
hw/rtl/median_threshold_crossing_tachometer.sv
dv/tb_median_threshold_crossing_tachometer.sv
